// ===== hdl/pem_pkg.sv =====
// Shared constants, types and codes of the Prewitt edge magnitude unit.
package pem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int GRAD_W     = 11;
    localparam int ABS_W      = 10;
    localparam int SQ_W       = 21;
    localparam int ROOT_IN_W  = 16;
    localparam int ROOT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_MODE = 2'd2;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQUARE,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/prewitt_edge_magnitude_unit.sv =====
// Top level of the Prewitt 3x3 edge magnitude unit: control, window and gradients.
//
// Pixels enter on the s-side stream (tdata = 8-bit grey value) in raster order.
// Results leave on the m-side stream: tdata holds edge_value, out_col, out_row
// from bit 0 up; tlast marks the last result of a frame. Pixels in the first two
// columns and rows of a frame produce no word.
// The user writes image size and magnitude mode via the write port only while idle; unenforced.
// One pixel at a time is processed; each pixel reads and rewrites one entry of
// the line-store RAM (both rows packed in one word), then steps through states:
//   pixel with no result:             read, calc
//   sum of absolutes (mode 0):        read, calc, out
//   root of squares (mode 1):         read, calc, square, 8-step root, out; no root if clamped
// The output register lets the next pixel be accepted while a result waits;
// a stalled receiver holds the unit only when a second result is ready.
// Reset restores 640x480, mode 0 and clears the position counters; the line
// store needs no clearing since the first full window of every row is built
// from freshly written entries.
module prewitt_edge_magnitude_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pem_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // pixel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pem_pkg::OUT_TDATA_W-1:0]     o_m_tdata,   // edge_value, out_col, out_row, pad
    output logic                                o_m_tlast,   // frame_end
    input  logic                                i_cfg_we,
    input  logic [pem_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pem_pkg::SIZE_W-1:0]          i_cfg_data
);

    localparam int SIZE_W = pem_pkg::SIZE_W;
    localparam int COL_W  = pem_pkg::COL_W;
    localparam int ROW_W  = pem_pkg::ROW_W;
    localparam int PIX_W  = pem_pkg::PIX_W;
    localparam int POS_W  = pem_pkg::POS_W;
    localparam int GRAD_W = pem_pkg::GRAD_W;
    localparam int ABS_W  = pem_pkg::ABS_W;
    localparam int SQ_W   = pem_pkg::SQ_W;
    localparam int RAM_W  = 2 * PIX_W;
    localparam int PAD_W  = pem_pkg::OUT_TDATA_W - PIX_W - 2 * POS_W;

    pem_pkg::t_state r_state, n_state;

    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_mode;

    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;

    logic [PIX_W-1:0] r_pixel;
    logic [COL_W-1:0] r_addr;
    logic             r_has_res;
    logic             r_last;
    logic [POS_W-1:0] r_res_col, r_res_row;

    logic [PIX_W-1:0] r_win [9];
    logic [ABS_W-1:0] r_abs_c, r_abs_r;
    logic [ABS_W:0]   r_sum;
    logic [PIX_W-1:0] r_mag;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_edge;
    logic [POS_W-1:0] r_out_col, r_out_row;
    logic             r_out_last;

    logic w_accept;
    logic w_ram_re, w_ram_we, w_sqrt_start;
    logic w_out_free;
    logic [RAM_W-1:0] w_rdata;

    logic [SIZE_W-1:0] w_ew, w_eh, w_c, w_r;
    logic              w_has_res, w_last;

    logic signed [GRAD_W-1:0] w_gc, w_gr;
    logic [SQ_W-1:0]          w_sq;

    logic                       w_sqrt_done;
    logic [pem_pkg::ROOT_W-1:0] w_root;

    // effective size: zero counts as one, oversize is capped
    always_comb begin
        if (r_width == '0) begin
            w_ew = SIZE_W'(1);
        end else if (r_width > SIZE_W'(pem_pkg::MAX_WIDTH)) begin
            w_ew = SIZE_W'(pem_pkg::MAX_WIDTH);
        end else begin
            w_ew = r_width;
        end
        if (r_height == '0) begin
            w_eh = SIZE_W'(1);
        end else if (r_height > SIZE_W'(pem_pkg::MAX_HEIGHT)) begin
            w_eh = SIZE_W'(pem_pkg::MAX_HEIGHT);
        end else begin
            w_eh = r_height;
        end
        w_c = SIZE_W'(r_col_cnt);
        w_r = SIZE_W'(r_row_cnt);
        w_has_res = (w_ew >= SIZE_W'(3)) && (w_eh >= SIZE_W'(3)) &&
                    (w_c >= SIZE_W'(2)) && (w_r >= SIZE_W'(2)) &&
                    (w_c < w_ew) && (w_r < w_eh);
        w_last = (w_c == w_ew - 1'b1) && (w_r == w_eh - 1'b1);
    end

    always_comb begin
        w_gc = '0;
        w_gr = '0;
        for (int k = 0; k < 3; k++) begin
            w_gc = w_gc + $signed({3'b000, r_win[k*3+2]}) - $signed({3'b000, r_win[k*3]});
            w_gr = w_gr + $signed({3'b000, r_win[6+k]}) - $signed({3'b000, r_win[k]});
        end
        w_sq = SQ_W'(r_abs_c * r_abs_c) + SQ_W'(r_abs_r * r_abs_r);
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pem_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = pem_pkg::ST_READ;
            end
            pem_pkg::ST_READ: n_state = pem_pkg::ST_CALC;
            pem_pkg::ST_CALC: begin
                if (!r_has_res) n_state = pem_pkg::ST_IDLE;
                else if (r_mode) n_state = pem_pkg::ST_SQUARE;
                else n_state = pem_pkg::ST_OUT;
            end
            pem_pkg::ST_SQUARE: begin
                if (w_sq[SQ_W-1:pem_pkg::ROOT_IN_W] != '0) n_state = pem_pkg::ST_OUT;
                else n_state = pem_pkg::ST_SQRT;
            end
            pem_pkg::ST_SQRT: begin
                if (w_sqrt_done) n_state = pem_pkg::ST_OUT;
            end
            pem_pkg::ST_OUT: begin
                if (w_out_free) n_state = pem_pkg::ST_IDLE;
            end
            default: n_state = pem_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        w_ram_re     = 1'b0;
        w_ram_we     = 1'b0;
        w_sqrt_start = 1'b0;
        unique case (r_state)
            pem_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                w_ram_re   = i_s_tvalid;
            end
            pem_pkg::ST_READ:   w_ram_we = 1'b1;
            pem_pkg::ST_SQUARE: w_sqrt_start = (w_sq[SQ_W-1:pem_pkg::ROOT_IN_W] == '0);
            default: ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pem_pkg::ST_IDLE;
            r_width     <= pem_pkg::RESET_WIDTH;
            r_height    <= pem_pkg::RESET_HEIGHT;
            r_mode      <= 1'b0;
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pem_pkg::CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                    pem_pkg::CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                    pem_pkg::CFG_MAGNITUDE_MODE: r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_c + 1'b1 >= w_ew) begin
                    r_col_cnt <= '0;
                    if (w_r + 1'b1 >= w_eh) r_row_cnt <= '0;
                    else r_row_cnt <= r_row_cnt + 1'b1;
                end else begin
                    r_col_cnt <= r_col_cnt + 1'b1;
                end
            end
            if (r_state == pem_pkg::ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel   <= i_s_tdata[PIX_W-1:0];
            r_addr    <= r_col_cnt;
            r_has_res <= w_has_res;
            r_last    <= w_last;
            r_res_col <= POS_W'(r_col_cnt - 2'd2);
            r_res_row <= POS_W'(r_row_cnt - 2'd2);
        end
        if (r_state == pem_pkg::ST_READ) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= w_rdata[RAM_W-1:PIX_W];
            r_win[5] <= w_rdata[PIX_W-1:0];
            r_win[8] <= r_pixel;
        end
        if (r_state == pem_pkg::ST_CALC) begin
            r_abs_c <= ABS_W'(w_gc < 0 ? -w_gc : w_gc);
            r_abs_r <= ABS_W'(w_gr < 0 ? -w_gr : w_gr);
            r_sum   <= (ABS_W + 1)'(w_gc < 0 ? -w_gc : w_gc) +
                       (ABS_W + 1)'(w_gr < 0 ? -w_gr : w_gr);
        end
        if (r_state == pem_pkg::ST_SQUARE) begin
            r_mag <= '1;
        end else if (r_state == pem_pkg::ST_SQRT && w_sqrt_done) begin
            r_mag <= w_root;
        end
        if (r_state == pem_pkg::ST_OUT && w_out_free) begin
            if (r_mode) r_out_edge <= r_mag;
            else if (r_sum[ABS_W:PIX_W] != '0) r_out_edge <= '1;
            else r_out_edge <= r_sum[PIX_W-1:0];
            r_out_col  <= r_res_col;
            r_out_row  <= r_res_row;
            r_out_last <= r_last;
        end
    end

    pem_line_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (pem_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata ({w_rdata[PIX_W-1:0], r_pixel}),
        .i_re    (w_ram_re),
        .i_raddr (r_col_cnt),
        .o_rdata (w_rdata)
    );

    pem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_sq[pem_pkg::ROOT_IN_W-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_row, r_out_col, r_out_edge};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == pem_pkg::ST_READ))
        else $error("accepted word did not start a line-store read");
    a_out_has_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pem_pkg::ST_OUT) |-> r_has_res)
        else $error("result stage reached for a pixel without a window");
    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == pem_pkg::ST_SQRT))
        else $error("root unit finished outside the root state");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && r_state == pem_pkg::ST_OUT)
        |=> (r_state == pem_pkg::ST_OUT))
        else $error("result stage left while output register was held");
`endif

endmodule

// ===== hdl/pem_line_ram.sv =====
// Generic simple dual-port RAM with registered read, holds the two line stores.
module pem_line_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pem_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module pem_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pem_pkg::ROOT_IN_W-1:0]    i_value,
    output logic                             o_done,
    output logic [pem_pkg::ROOT_W-1:0]       o_root
);

    localparam int REM_W = pem_pkg::ROOT_W + 1;
    localparam int CNT_W = $clog2(pem_pkg::ROOT_W);

    logic [pem_pkg::ROOT_IN_W-1:0] r_val;
    logic [REM_W-1:0]              r_rem;
    logic [pem_pkg::ROOT_W-1:0]    r_root;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;
    logic             w_fit;

    always_comb begin
        w_rem_sh = {r_rem, r_val[pem_pkg::ROOT_IN_W-1 -: 2]};
        w_trial  = (REM_W + 2)'({r_root, 2'b01});
        w_fit    = (w_rem_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(pem_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            r_val <= {r_val[pem_pkg::ROOT_IN_W-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (w_fit) begin
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[pem_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_sh);
                r_root <= {r_root[pem_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for prewitt_edge_magnitude_unit: streams pixels and checks edge words.

typedef struct {
    logic [7:0] value;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
} t_edge_word;

class edge_map_tracker;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        mode_reg;
    logic [7:0]  row_up1 [pem_pkg::MAX_WIDTH];
    logic [7:0]  row_up2 [pem_pkg::MAX_WIDTH];
    logic [7:0]  win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    t_edge_word  edge_words_due [$];
    int unsigned edge_faults;
    int unsigned words_seen;

    function new();
        width_reg   = pem_pkg::RESET_WIDTH;
        height_reg  = pem_pkg::RESET_HEIGHT;
        mode_reg    = 1'b0;
        foreach (row_up1[i]) begin
            row_up1[i] = '0;
            row_up2[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        col_pos     = 0;
        row_pos     = 0;
        edge_faults = 0;
        words_seen  = 0;
    endfunction

    function void write_reg(logic [pem_pkg::CFG_IDX_W-1:0] idx,
                            logic [pem_pkg::SIZE_W-1:0] data);
        case (idx)
            pem_pkg::CFG_IMAGE_WIDTH:    width_reg  = data;
            pem_pkg::CFG_IMAGE_HEIGHT:   height_reg = data;
            pem_pkg::CFG_MAGNITUDE_MODE: mode_reg   = data[0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_size(logic [10:0] v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // bitwise search, largest root whose square fits
    function int unsigned int_root(int unsigned v);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = 11; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function bit at_frame_start();
        return col_pos == 0 && row_pos == 0;
    endfunction

    function void take_pixel(logic [7:0] p);
        int unsigned ew, eh, c, r, ax, ay, mag;
        int          gx, gy, k;
        logic [7:0]  up1, up2;
        t_edge_word  w;
        ew  = eff_size(width_reg, pem_pkg::MAX_WIDTH);
        eh  = eff_size(height_reg, pem_pkg::MAX_HEIGHT);
        c   = col_pos % pem_pkg::MAX_WIDTH;
        r   = row_pos;
        up1 = row_up1[c];
        up2 = row_up2[c];
        row_up2[c] = up1;
        row_up1[c] = p;
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = p;
        if (ew >= 3 && eh >= 3 && c >= 2 && r >= 2 && c < ew && r < eh) begin
            gx = 0;
            gy = 0;
            for (k = 0; k < 3; k++) begin
                gx += int'(win[k][2]) - int'(win[k][0]);
                gy += int'(win[2][k]) - int'(win[0][k]);
            end
            ax  = (gx < 0) ? -gx : gx;
            ay  = (gy < 0) ? -gy : gy;
            mag = mode_reg ? int_root(ax * ax + ay * ay) : ax + ay;
            if (mag > 255) mag = 255;
            w.value = mag[7:0];
            w.col   = 10'(c - 2);
            w.row   = 10'(r - 2);
            w.last  = (c == ew - 1) && (r == eh - 1);
            edge_words_due.push_back(w);
        end
        if (c + 1 >= ew) begin
            col_pos = 0;
            row_pos = (r + 1 >= eh) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function void check_edge_word(logic [31:0] d, logic last);
        t_edge_word w;
        words_seen++;
        if (edge_words_due.size() == 0) begin
            edge_faults++;
            if (edge_faults <= 10)
                $display("edge word %0d unexpected: data=%h last=%b", words_seen, d, last);
            return;
        end
        w = edge_words_due.pop_front();
        if (d[7:0] !== w.value || d[17:8] !== w.col || d[27:18] !== w.row ||
            d[31:28] !== 4'd0 || last !== w.last) begin
            edge_faults++;
            if (edge_faults <= 10)
                $display({"edge word %0d: exp val=%0d col=%0d row=%0d last=%b, ",
                          "got val=%0d col=%0d row=%0d pad=%h last=%b"},
                         words_seen, w.value, w.col, w.row, w.last,
                         d[7:0], d[17:8], d[27:18], d[31:28], last);
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_PIXELS = 1080;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [pem_pkg::IN_TDATA_W-1:0]  i_s_tdata;    // pixel
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [pem_pkg::OUT_TDATA_W-1:0] o_m_tdata;    // edge_value, out_col, out_row, pad
    logic                            o_m_tlast;    // frame_end
    logic                            i_cfg_we;
    logic [pem_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [pem_pkg::SIZE_W-1:0]      i_cfg_data;

    edge_map_tracker sb;
    int unsigned     burst_left;
    bit              hold_off_req;

    prewitt_edge_magnitude_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_edge_word(o_m_tdata, o_m_tlast);
    end

    // receiver: random stall pattern, replaced when its countdown runs out, plus one long hold-off on request
    initial begin : ready_gen
        logic [15:0] stall_pat;
        int unsigned pat_left;
        stall_pat  = '1;
        pat_left   = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (pat_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom) & 16'($urandom);
                    default: stall_pat = 16'($urandom) | 16'($urandom);
                endcase
                pat_left = 64;
            end
            i_m_tready <= stall_pat[pat_left % 16];
            pat_left--;
        end
    end

    task automatic push_pixel(input logic [7:0] p);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        sb.take_pixel(p);
    endtask

    // stop sending and let the unit drain fully
    task automatic settle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.edge_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_unit(input logic [10:0] w, input logic [10:0] h, input logic m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pem_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        sb.write_reg(pem_pkg::CFG_IMAGE_WIDTH, w);
        i_cfg_idx  <= pem_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        sb.write_reg(pem_pkg::CFG_IMAGE_HEIGHT, h);
        i_cfg_idx  <= pem_pkg::CFG_MAGNITUDE_MODE;
        i_cfg_data <= {10'd0, m};
        @(posedge i_clk);
        sb.write_reg(pem_pkg::CFG_MAGNITUDE_MODE, {10'd0, m});
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pixel(int unsigned style, int unsigned base);
        case (style)
            1: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            2: return 8'(base + $urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [10:0] pick_side();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'($urandom_range(1, 2));
            2: return 11'($urandom_range(13, 24));
            default: return 11'($urandom_range(3, 12));
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0]  patch [$];
        logic [10:0] new_w, new_h;
        logic        new_mode;
        int unsigned random_pixels, frames, style, base, i;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = pem_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data   = '0;
        hold_off_req = 1'b0;
        burst_left   = 0;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // steep corner, sum of absolute gradients saturates
        program_unit(11'd3, 11'd3, 1'b0);
        patch = {8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
        foreach (patch[k]) push_pixel(patch[k]);
        settle();
        // gentle slope, unclamped root with a negative gradient term
        program_unit(11'd3, 11'd3, 1'b1);
        patch = {8'd10, 8'd12, 8'd14, 8'd11, 8'd13, 8'd15, 8'd9, 8'd20, 8'd30};
        foreach (patch[k]) push_pixel(patch[k]);
        settle();
        // zero size counts as one: no words
        program_unit(11'd0, 11'd0, 1'b1);
        repeat (4) push_pixel(8'($urandom_range(0, 255)));
        settle();

        // long receiver hold-off while pixels keep coming
        program_unit(11'd12, 11'd8, 1'b0);
        for (i = 0; i < 96; i++) begin
            if (i == 40) hold_off_req = 1'b1;
            push_pixel(pick_pixel(0, 0));
        end
        settle();

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            new_w    = pick_side();
            new_h    = pick_side();
            new_mode = 1'($urandom_range(0, 1));
            // a wider row mid-frame would read stale line-store entries
            if (!sb.at_frame_start() &&
                sb.eff_size(new_w, pem_pkg::MAX_WIDTH) >
                sb.eff_size(sb.width_reg, pem_pkg::MAX_WIDTH))
                new_w = sb.width_reg;
            program_unit(new_w, new_h, new_mode);
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 252);
            if ($urandom_range(0, 7) != 0) begin
                frames = $urandom_range(1, 3);
                while (frames != 0 && random_pixels < RANDOM_PIXELS) begin
                    push_pixel(pick_pixel(style, base));
                    random_pixels++;
                    if (sb.at_frame_start()) frames--;
                end
            end else begin
                repeat ($urandom_range(1, 40)) begin
                    push_pixel(pick_pixel(style, base));
                    random_pixels++;
                end
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (sb.edge_faults == 0 && sb.edge_words_due.size() == 0)
            $display("prewitt_edge_magnitude_unit test passed");
        else
            $display("prewitt_edge_magnitude_unit test failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("prewitt_edge_magnitude_unit test failed");
        $finish;
    end

endmodule
